/* rtl/adsc_pkg.sv */
package adsc_pkg;

   // field and datapath widths
   localparam int SAMPLE_BITS     = 24;
   localparam int ALPHA_FRAC_BITS = 16;
   localparam int ALPHA_BITS      = 16;
   localparam int ACC_BITS        = SAMPLE_BITS + ALPHA_FRAC_BITS;
   localparam int COEFF_BITS      = 48;
   localparam int MUL_BITS        = 32;
   localparam int PROD_BITS       = 2 * MUL_BITS;
   localparam int SUM_BITS        = 56;
   localparam int RES_BITS        = SUM_BITS + 2;
   localparam int CSR_IDX_BITS    = 2;

   // calibration product is out of range when its upper limb reaches this bit
   localparam int HI_LIMIT_BIT    = 20;

   // register reset values
   localparam logic [ALPHA_BITS-1:0] ALPHA_RESET  = '0;
   localparam logic [COEFF_BITS-1:0] GAIN_RESET   = COEFF_BITS'(64'd4294967296);
   localparam logic [COEFF_BITS-1:0] OFFSET_RESET = '0;

   // saturation limits of the signed result
   localparam logic [COEFF_BITS-1:0] MAX_RESULT = {1'b0, {(COEFF_BITS-1){1'b1}}};
   localparam logic [COEFF_BITS-1:0] MIN_RESULT = {1'b1, {(COEFF_BITS-1){1'b0}}};

   // configuration register indexes
   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_ALPHA  = 2'd0,
      CSR_GAIN   = 2'd1,
      CSR_OFFSET = 2'd2
   } csr_index_type;

endpackage

/* rtl/adc_sample_smooth_calibrate_core.sv */
// One request at a time: req_stall is high until the result is loaded into the output register,
// which waits while a pending response is stalled. The single shared 32x32 multiplier runs three
// smoothing (skipped at alpha zero) and four calibration partial products in turn. A new request
// can be taken in the cycle after the previous one reaches the output register.
// Reset (synchronous, active high) clears the accumulator, restores alpha 0, gain 1.0,
// offset 0 and leaves no response pending.
module adc_sample_smooth_calibrate_core import adsc_pkg::*; (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [SAMPLE_BITS-1:0]       req_raw_sample,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [SAMPLE_BITS-1:0]       rsp_smoothed_sample,
   output logic signed [COEFF_BITS-1:0] rsp_calibrated_value,
   output logic                         rsp_calibrated_saturated,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [CSR_IDX_BITS-1:0]      csr_index,
   input  logic [COEFF_BITS-1:0]        csr_data
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SM_LO,
      ST_SM_HI,
      ST_SM_NEW,
      ST_CAL_00,
      ST_CAL_01,
      ST_CAL_10,
      ST_CAL_11,
      ST_FINISH
   } state_type;

   state_type                 state_ff;
   logic [ALPHA_BITS-1:0]     alpha_ff;
   logic [COEFF_BITS-1:0]     gain_ff;
   logic [COEFF_BITS-1:0]     offset_ff;
   logic [ACC_BITS-1:0]       acc_ff;
   logic [SAMPLE_BITS-1:0]    sample_ff;
   logic [COEFF_BITS-1:0]     gain_mag_ff;
   logic                      gain_neg_ff;
   logic [SUM_BITS-1:0]       sum_ff;
   logic                      big_ff;
   logic                      rsp_valid_ff;
   logic [SAMPLE_BITS-1:0]    smoothed_ff;
   logic [COEFF_BITS-1:0]     calib_ff;
   logic                      sat_ff;

   logic [MUL_BITS-1:0]       mul_a;
   logic [MUL_BITS-1:0]       mul_b;
   logic [PROD_BITS-1:0]      prod;
   logic [COEFF_BITS-1:0]     gain_mag_in;
   logic signed [RES_BITS-1:0] prod_s;
   logic signed [RES_BITS-1:0] res_s;
   logic                      res_over;
   logic [COEFF_BITS-1:0]     calib_in;
   logic                      sat_in;
   logic                      out_free;

   // handshake outputs
   assign req_stall                = (state_ff != ST_IDLE);
   assign csr_ready                = 1'b1;
   assign rsp_valid                = rsp_valid_ff;
   assign rsp_smoothed_sample      = smoothed_ff;
   assign rsp_calibrated_value     = calib_ff;
   assign rsp_calibrated_saturated = sat_ff;
   assign out_free                 = !rsp_valid_ff || !rsp_stall;

   // gain magnitude for the unsigned limb products
   assign gain_mag_in = gain_ff[COEFF_BITS-1] ? (~gain_ff + 1'b1) : gain_ff;

   // select operands of the shared multiplier for the current step
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         ST_SM_LO: begin
            mul_a = MUL_BITS'(alpha_ff);
            mul_b = acc_ff[MUL_BITS-1:0];
         end
         ST_SM_HI: begin
            mul_a = MUL_BITS'(alpha_ff);
            mul_b = MUL_BITS'(acc_ff[ACC_BITS-1:MUL_BITS]);
         end
         ST_SM_NEW: begin
            mul_a = MUL_BITS'({1'b1, {ALPHA_FRAC_BITS{1'b0}}} - {1'b0, alpha_ff});
            mul_b = MUL_BITS'(sample_ff);
         end
         ST_CAL_00: begin
            mul_a = gain_mag_ff[MUL_BITS-1:0];
            mul_b = acc_ff[MUL_BITS-1:0];
         end
         ST_CAL_01: begin
            mul_a = gain_mag_ff[MUL_BITS-1:0];
            mul_b = MUL_BITS'(acc_ff[ACC_BITS-1:MUL_BITS]);
         end
         ST_CAL_10: begin
            mul_a = MUL_BITS'(gain_mag_ff[COEFF_BITS-1:MUL_BITS]);
            mul_b = acc_ff[MUL_BITS-1:0];
         end
         ST_CAL_11: begin
            mul_a = MUL_BITS'(gain_mag_ff[COEFF_BITS-1:MUL_BITS]);
            mul_b = MUL_BITS'(acc_ff[ACC_BITS-1:MUL_BITS]);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod = mul_a * mul_b;

   // apply sign and offset, then clip to the signed result range
   always_comb begin
      prod_s   = gain_neg_ff ? -$signed({2'b00, sum_ff}) : $signed({2'b00, sum_ff});
      res_s    = prod_s + RES_BITS'($signed(offset_ff));
      res_over = (res_s[RES_BITS-1:COEFF_BITS-1] != '0)
              && (res_s[RES_BITS-1:COEFF_BITS-1] != '1);
      calib_in = res_s[COEFF_BITS-1:0];
      sat_in   = 1'b0;
      priority if (big_ff) begin
         calib_in = gain_neg_ff ? MIN_RESULT : MAX_RESULT;
         sat_in   = 1'b1;
      end else if (res_over) begin
         calib_in = res_s[RES_BITS-1] ? MIN_RESULT : MAX_RESULT;
         sat_in   = 1'b1;
      end else begin
         calib_in = res_s[COEFF_BITS-1:0];
         sat_in   = 1'b0;
      end
   end

   // sequencer, datapath and output registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         alpha_ff     <= ALPHA_RESET;
         gain_ff      <= GAIN_RESET;
         offset_ff    <= OFFSET_RESET;
         acc_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // take configuration writes
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_ALPHA:  alpha_ff  <= csr_data[ALPHA_BITS-1:0];
               CSR_GAIN:   gain_ff   <= csr_data;
               CSR_OFFSET: offset_ff <= csr_data;
               default:    ;
            endcase
         end

         // drop the response once taken, unless the next one loads now
         if (rsp_valid_ff && !rsp_stall && state_ff != ST_FINISH) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  sample_ff   <= req_raw_sample;
                  gain_mag_ff <= gain_mag_in;
                  gain_neg_ff <= gain_ff[COEFF_BITS-1];
                  if (alpha_ff == '0) begin
                     acc_ff   <= {req_raw_sample, {ALPHA_FRAC_BITS{1'b0}}};
                     state_ff <= ST_CAL_00;
                  end else begin
                     state_ff <= ST_SM_LO;
                  end
               end
            end
            ST_SM_LO: begin
               sum_ff   <= SUM_BITS'(prod >> ALPHA_FRAC_BITS);
               state_ff <= ST_SM_HI;
            end
            ST_SM_HI: begin
               sum_ff   <= sum_ff + SUM_BITS'(prod << (MUL_BITS - ALPHA_FRAC_BITS));
               state_ff <= ST_SM_NEW;
            end
            ST_SM_NEW: begin
               acc_ff   <= ACC_BITS'(sum_ff + prod[SUM_BITS-1:0]);
               state_ff <= ST_CAL_00;
            end
            ST_CAL_00: begin
               sum_ff   <= SUM_BITS'(prod >> MUL_BITS);
               state_ff <= ST_CAL_01;
            end
            ST_CAL_01: begin
               sum_ff   <= sum_ff + prod[SUM_BITS-1:0];
               state_ff <= ST_CAL_10;
            end
            ST_CAL_10: begin
               sum_ff   <= sum_ff + prod[SUM_BITS-1:0];
               state_ff <= ST_CAL_11;
            end
            ST_CAL_11: begin
               sum_ff   <= sum_ff + SUM_BITS'(prod << MUL_BITS);
               big_ff   <= |prod[PROD_BITS-1:HI_LIMIT_BIT];
               state_ff <= ST_FINISH;
            end
            ST_FINISH: begin
               // hold until the output register is free
               if (out_free) begin
                  smoothed_ff  <= acc_ff[ACC_BITS-1:ALPHA_FRAC_BITS];
                  calib_ff     <= calib_in;
                  sat_ff       <= sat_in;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

/* verif/testbench.sv */
module testbench;
   import adsc_pkg::*;

   localparam longint RESULT_HI = 64'sd140737488355327;
   localparam longint RESULT_LO = -64'sd140737488355328;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SPARE = 2'd3;
   localparam logic [COEFF_BITS-1:0] COEFF_MAX = {1'b0, {(COEFF_BITS-1){1'b1}}};
   localparam logic [COEFF_BITS-1:0] COEFF_MIN = {1'b1, {(COEFF_BITS-1){1'b0}}};
   localparam int CYCLE_LIMIT = 200000;
   localparam int PHASES = 8;
   localparam int PHASE_ITEMS = 110;

   typedef struct {
      logic [SAMPLE_BITS-1:0] smoothed;
      logic [COEFF_BITS-1:0]  value;
      logic                   saturated;
   } reading_type;

   // Tracks registers and the smoothing accumulator, predicts each reading
   class smooth_cal_tracker;
      logic [ALPHA_BITS-1:0] alpha;
      logic [COEFF_BITS-1:0] gain;
      logic [COEFF_BITS-1:0] offset;
      logic [ACC_BITS-1:0]   accum;
      reading_type           readings_due[$];
      int                    errors;

      function new();
         alpha = ALPHA_RESET;
         gain = GAIN_RESET;
         offset = OFFSET_RESET;
         accum = '0;
         errors = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_BITS-1:0] idx, logic [COEFF_BITS-1:0] data);
         case (idx)
            CSR_ALPHA:  alpha = data[ALPHA_BITS-1:0];
            CSR_GAIN:   gain = data;
            CSR_OFFSET: offset = data;
            default: ;
         endcase
      endfunction

      function void take_sample(logic [SAMPLE_BITS-1:0] raw);
         logic [63:0]           blend;
         logic [COEFF_BITS-1:0] gmag;
         logic                  gneg;
         logic [23:0]           upper;
         logic [127:0]          full;
         logic [63:0]           q;
         logic                  big;
         longint                sum;
         reading_type           r;
         // smooth: pass-through at alpha zero, else weighted blend truncated
         if (alpha == '0) begin
            accum = {raw, {ALPHA_FRAC_BITS{1'b0}}};
         end else begin
            blend = ((64'(alpha) * 64'(accum)) >> ALPHA_FRAC_BITS)
                  + (64'd65536 - 64'(alpha)) * 64'(raw);
            accum = blend[ACC_BITS-1:0];
         end
         // calibrate: |gain| * accum in Q.16, upper limb product flags overflow
         gneg = gain[COEFF_BITS-1];
         gmag = gneg ? -gain : gain;
         upper = 24'(32'(gmag[47:32]) * 32'(accum[39:32]));
         full = 128'(gmag) * 128'(accum);
         q = full[95:32];
         big = (upper[23:HI_LIMIT_BIT] != 0) || (q[63:62] != 0);
         r.smoothed = accum[ACC_BITS-1:ALPHA_FRAC_BITS];
         r.saturated = 1'b0;
         if (big) begin
            r.value = gneg ? MIN_RESULT : MAX_RESULT;
            r.saturated = 1'b1;
         end else begin
            sum = (gneg ? -longint'(q) : longint'(q)) + longint'($signed(offset));
            if (sum > RESULT_HI) begin
               r.value = MAX_RESULT;
               r.saturated = 1'b1;
            end else if (sum < RESULT_LO) begin
               r.value = MIN_RESULT;
               r.saturated = 1'b1;
            end else begin
               r.value = sum[COEFF_BITS-1:0];
            end
         end
         readings_due.push_back(r);
      endfunction

      function void check_reading(logic [SAMPLE_BITS-1:0] smoothed,
                                  logic [COEFF_BITS-1:0] value, logic saturated);
         reading_type r;
         if (readings_due.size() == 0) begin
            $display("%0t: unexpected reading smoothed %h value %h sat %b",
                     $time, smoothed, value, saturated);
            errors++;
            return;
         end
         r = readings_due.pop_front();
         if (smoothed !== r.smoothed) begin
            $display("%0t: smoothed_sample expected %h actual %h", $time, r.smoothed, smoothed);
            errors++;
         end
         if (value !== r.value) begin
            $display("%0t: calibrated_value expected %h actual %h", $time, r.value, value);
            errors++;
         end
         if (saturated !== r.saturated) begin
            $display("%0t: calibrated_saturated expected %b actual %b",
                     $time, r.saturated, saturated);
            errors++;
         end
      endfunction
   endclass

   logic                         clock;
   logic                         reset = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_stall;
   logic [SAMPLE_BITS-1:0]       req_raw_sample = '0;
   logic                         rsp_valid;
   logic                         rsp_stall = 1'b0;
   logic [SAMPLE_BITS-1:0]       rsp_smoothed_sample;
   logic signed [COEFF_BITS-1:0] rsp_calibrated_value;
   logic                         rsp_calibrated_saturated;
   logic                         csr_valid = 1'b0;
   logic                         csr_ready;
   logic [CSR_IDX_BITS-1:0]      csr_index = CSR_ALPHA;
   logic [COEFF_BITS-1:0]        csr_data = '0;

   smooth_cal_tracker tracker = new();
   bit idle_on = 1'b0;
   int stall_left = 0;
   int cycles = 0;

   adc_sample_smooth_calibrate_core dut (
      .clock                    (clock),
      .reset                    (reset),
      .req_valid                (req_valid),
      .req_stall                (req_stall),
      .req_raw_sample           (req_raw_sample),
      .rsp_valid                (rsp_valid),
      .rsp_stall                (rsp_stall),
      .rsp_smoothed_sample      (rsp_smoothed_sample),
      .rsp_calibrated_value     (rsp_calibrated_value),
      .rsp_calibrated_saturated (rsp_calibrated_saturated),
      .csr_valid                (csr_valid),
      .csr_ready                (csr_ready),
      .csr_index                (csr_index),
      .csr_data                 (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // abort a hung run
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("[adc_sample_smooth_calibrate_core] ERROR");
         $finish;
      end
   end

   // predict on every accepted sample transaction
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall)
         tracker.take_sample(req_raw_sample);
   end

   // check accepted readings, then stall the response side in bursts
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         tracker.check_reading(rsp_smoothed_sample, rsp_calibrated_value,
                               rsp_calibrated_saturated);
      if (stall_left != 0) begin
         rsp_stall <= 1'b1;
         stall_left <= stall_left - 1;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
         rsp_stall <= 1'b1;
         stall_left <= $urandom_range(0, 3);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   task automatic send_sample(logic [SAMPLE_BITS-1:0] raw);
      int gap;
      gap = (idle_on && $urandom_range(0, 2) == 0) ? $urandom_range(1, 4) : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_raw_sample <= raw;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic write_csr(logic [CSR_IDX_BITS-1:0] idx, logic [COEFF_BITS-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      tracker.write_reg(idx, data);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // hold the sender until every predicted reading has come back
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (tracker.readings_due.size() != 0) @(posedge clock);
   endtask

   function automatic logic [COEFF_BITS-1:0] pick_coeff();
      logic [63:0] r;
      r = {$urandom, $urandom};
      case ($urandom_range(0, 5))
         0: return COEFF_MAX;
         1: return COEFF_MIN;
         2: return '0;
         3: return r[COEFF_BITS-1:0];
         4: return GAIN_RESET;
         default: return $signed(r[COEFF_BITS-1:0]) >>> $urandom_range(8, 44);
      endcase
   endfunction

   function automatic logic [COEFF_BITS-1:0] pick_alpha();
      logic [63:0] r;
      logic [ALPHA_BITS-1:0] a;
      r = {$urandom, $urandom};
      case ($urandom_range(0, 4))
         0: a = '0;
         1: a = '1;
         2: a = 16'd1;
         default: a = r[ALPHA_BITS-1:0];
      endcase
      // junk above the alpha field must be ignored
      return {r[COEFF_BITS-1:ALPHA_BITS], a};
   endfunction

   function automatic logic [SAMPLE_BITS-1:0] pick_sample();
      case ($urandom_range(0, 7))
         0: return '1;
         1: return '0;
         2: return SAMPLE_BITS'($urandom_range(0, 255));
         default: return SAMPLE_BITS'($urandom);
      endcase
   endfunction

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // reset settings: pass-through, unity gain, no offset
      send_sample('0);
      send_sample('1);
      send_sample(24'h800000);
      send_sample(24'h000001);
      send_sample(24'hAAAAAA);
      send_sample(24'h555555);
      drain();

      // slowest smoothing at unity gain
      write_csr(CSR_ALPHA, 48'h0000_0000_FFFF);
      write_csr(CSR_GAIN, GAIN_RESET);
      write_csr(CSR_OFFSET, OFFSET_RESET);
      send_sample('1);
      send_sample('0);
      send_sample('1);
      drain();

      // huge product, positive and negative
      write_csr(CSR_ALPHA, 48'h0000_0000_8000);
      write_csr(CSR_GAIN, COEFF_MAX);
      write_csr(CSR_OFFSET, COEFF_MIN);
      send_sample('1);
      send_sample(24'h000010);
      drain();
      write_csr(CSR_GAIN, COEFF_MIN);
      write_csr(CSR_OFFSET, COEFF_MAX);
      send_sample('1);
      send_sample('0);
      drain();

      // sum overflow without a huge product
      write_csr(CSR_ALPHA, '0);
      write_csr(CSR_GAIN, 48'h0080_0000_0000);
      send_sample('1);
      drain();
      write_csr(CSR_OFFSET, COEFF_MIN);
      write_csr(CSR_GAIN, 48'hFF80_0000_0000);
      send_sample('1);
      drain();

      // zero gain leaves the offset alone; spare index changes nothing
      write_csr(CSR_GAIN, '0);
      write_csr(CSR_SPARE, COEFF_BITS'({$urandom, $urandom}));
      send_sample('1);
      drain();
      write_csr(CSR_OFFSET, COEFF_MAX);
      send_sample(24'h123456);
      drain();

      // random phases, each with its own settings; last one runs flat out
      for (int p = 0; p < PHASES; p++) begin
         drain();
         write_csr(CSR_ALPHA, pick_alpha());
         write_csr(CSR_GAIN, pick_coeff());
         write_csr(CSR_OFFSET, pick_coeff());
         if ($urandom_range(0, 3) == 0)
            write_csr(CSR_SPARE, COEFF_BITS'({$urandom, $urandom}));
         idle_on = (p == PHASES - 1) ? 1'b0 : ($urandom_range(0, 3) != 0);
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            if (p == 2 && i == PHASE_ITEMS / 2)
               drain();
            send_sample(pick_sample());
         end
      end

      drain();
      repeat (20) @(posedge clock);
      if (tracker.errors == 0 && tracker.readings_due.size() == 0) begin
         $display("[adc_sample_smooth_calibrate_core] OK");
      end else begin
         $display("[adc_sample_smooth_calibrate_core] ERROR");
      end
      $finish;
   end

endmodule

/* files.f */
rtl/adsc_pkg.sv
rtl/adc_sample_smooth_calibrate_core.sv
verif/testbench.sv
